// ===== src/drpa_pkg.sv =====
// Package for the detector ring parameter averager: types, constants, status codes.
// No dependencies.
`timescale 1ns / 1ps
package drpa_pkg;
   localparam int BarrelBinsDefault   = 171;
   localparam int EndcapRingsDefault  = 40;
   localparam int BarrelOffsetDefault = 85;
   localparam int FractionBitsDefault = 16;

   localparam int SumWidth   = 48;
   localparam int CountWidth = 12;
   localparam logic [CountWidth-1:0] CountMax = '1;
   localparam logic [31:0] BarrelLimitReset = 32'd839000000;
   localparam logic [5:0]  FirstRadiusReset = 6'd11;

   localparam logic [1:0] StatusAccum     = 2'd0;
   localparam logic [1:0] StatusDropped   = 2'd1;
   localparam logic [1:0] StatusReadOk    = 2'd2;
   localparam logic [1:0] StatusReadEmpty = 2'd3;

   localparam logic [1:0] RegionBarrel = 2'd0;
   localparam logic [1:0] RegionPlus   = 2'd1;
   localparam logic [1:0] RegionMinus  = 2'd2;

   localparam logic CmdAccum = 1'b0;
   localparam logic CmdRead  = 1'b1;

   localparam logic CsrBarrelLimit = 1'b0;
   localparam logic CsrFirstRadius = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] raw_id;
      logic signed [31:0] amplitude;
      logic signed [31:0] start_time;
      logic signed [31:0] alpha_shape;
      logic signed [31:0] beta_shape;
      logic [1:0]  read_region;
      logic [7:0]  read_ring;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  region;
      logic [7:0]  ring_number;
      logic signed [31:0] mean_amplitude;
      logic signed [31:0] mean_start_time;
      logic signed [31:0] mean_alpha;
      logic signed [31:0] mean_beta;
      logic [11:0] crystal_count;
   } rsp_type;

   typedef struct packed {
      logic [0:0]  index;
      logic [31:0] data;
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLASS, ST_READ, ST_WRITE, ST_DIVIDE, ST_OUT
   } state_type;
endpackage

// ===== src/drpa_if.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on drpa_pkg.
`timescale 1ns / 1ps
interface drpa_req_if;
   logic valid;
   logic ready;
   drpa_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface drpa_rsp_if;
   logic valid;
   logic ready;
   drpa_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface drpa_csr_if;
   logic valid;
   logic ready;
   drpa_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/drpa_ring_find.sv =====
// Endcap ring search: one ring radius compared per cycle against the squared distance.
// Depends on drpa_pkg.
`timescale 1ns / 1ps
module drpa_ring_find #(
   parameter int ENDCAP_RINGS = drpa_pkg::EndcapRingsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [6:0]  grid_x,
   input  logic [6:0]  grid_y,
   input  logic [5:0]  first_radius,
   output logic        done,
   output logic        found,
   output logic [$clog2(ENDCAP_RINGS+1)-1:0] ring
);
   localparam int RW = $clog2(ENDCAP_RINGS + 1);

   logic          busy_ff, busy_in;
   logic [RW-1:0] idx_ff, idx_in;
   logic [15:0]   dist_ff, dist_in;
   logic [8:0]    lo_ff, lo_in;
   logic signed [8:0] dx, dy;
   logic [17:0]   lo_sq, hi_sq;
   logic          hit, last;

   assign dx    = $signed({1'b0, grid_x, 1'b0}) - 9'sd101;
   assign dy    = $signed({1'b0, grid_y, 1'b0}) - 9'sd101;
   assign lo_sq = lo_ff * lo_ff;
   assign hi_sq = (lo_ff + 9'd2) * (lo_ff + 9'd2);
   assign hit   = ({2'b0, dist_ff} > lo_sq) && ({2'b0, dist_ff} < hi_sq);
   assign last  = (idx_ff == RW'(ENDCAP_RINGS - 1));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      dist_in = dist_ff;
      lo_in   = lo_ff;
      done    = 1'b0;
      found   = 1'b0;
      ring    = idx_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         dist_in = 16'(dx) * 16'(dx) + 16'(dy) * 16'(dy);
         lo_in   = {2'b0, first_radius, 1'b0};
      end else if (busy_ff) begin
         if (hit || last) begin
            done    = 1'b1;
            found   = hit;
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + RW'(1);
            lo_in  = lo_ff + 9'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      idx_ff  <= idx_in;
      dist_ff <= dist_in;
      lo_ff   <= lo_in;
   end
endmodule

// ===== src/drpa_divider.sv =====
// Signed 48-bit by 12-bit restoring divider, one quotient bit per cycle, truncating.
// Depends on drpa_pkg.
`timescale 1ns / 1ps
module drpa_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic signed [drpa_pkg::SumWidth-1:0] dividend,
   input  logic [drpa_pkg::CountWidth-1:0]      divisor,
   output logic        done,
   output logic [31:0] quotient
);
   localparam int W = drpa_pkg::SumWidth;

   logic          busy_ff, busy_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [drpa_pkg::CountWidth:0] rem_ff, rem_in;
   logic [drpa_pkg::CountWidth-1:0] den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [drpa_pkg::CountWidth:0] trial;
   logic [W-1:0]  qneg;

   assign trial = {rem_ff[drpa_pkg::CountWidth-1:0], quo_ff[W-1]};
   assign qneg  = neg_ff ? (~quo_ff + W'(1)) : quo_ff;
   assign quotient = qneg[31:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      done    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(W);
         neg_in  = dividend[W-1];
         quo_in  = dividend[W-1] ? W'(-dividend) : dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            done    = 1'b1;
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 6'd1;
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end
endmodule

// ===== src/drpa_bin_store.sv =====
// Bin memory: one row per bin with four 48-bit sums and a 12-bit count.
// Synchronous read, data valid in the cycle after rd_en; clearing pass after reset. Depends on drpa_pkg.
`timescale 1ns / 1ps
module drpa_bin_store #(
   parameter int BINS = 251
) (
   input  logic        clock,
   input  logic        reset,
   output logic        clear_busy,
   input  logic        rd_en,
   input  logic [$clog2(BINS)-1:0] rd_addr,
   output logic [4*drpa_pkg::SumWidth+drpa_pkg::CountWidth-1:0] rd_data,
   input  logic        wr_en,
   input  logic [$clog2(BINS)-1:0] wr_addr,
   input  logic [4*drpa_pkg::SumWidth+drpa_pkg::CountWidth-1:0] wr_data
);
   localparam int AW = $clog2(BINS);
   localparam int DW = 4 * drpa_pkg::SumWidth + drpa_pkg::CountWidth;

   logic [DW-1:0] mem [BINS];
   logic [AW-1:0] clr_ff, clr_in;
   logic          clearing_ff, clearing_in;

   assign clear_busy = clearing_ff;

   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         if (clr_ff == AW'(BINS - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_in = clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== src/detector_ring_parameter_averager_core.sv =====
// Channel    | Dir | Payload
// req        | in  | command, raw_id, four Q16.16 parameters, read_region, read_ring
// rsp        | out | status, region, ring_number, four means, crystal_count
// csr        | in  | register index, 32-bit write data
// A barrel accumulate passes through classify and issue the memory read,
// read-modify-write, then output. An endcap item adds a ring search over up to
// ENDCAP_RINGS rings. A read of a filled bin runs four 48-step divisions in parallel
// before its output; other reads skip the division.
// After reset the bin memory is cleared one row a cycle, with req not ready until all BINS rows are clear.
// The result register holds until taken; the next item is accepted only then.
// Depends on drpa_pkg, drpa_if, drpa_ring_find, drpa_divider, drpa_bin_store.
`timescale 1ns / 1ps
module detector_ring_parameter_averager_core #(
   parameter int BARREL_BINS   = drpa_pkg::BarrelBinsDefault,
   parameter int ENDCAP_RINGS  = drpa_pkg::EndcapRingsDefault,
   parameter int BARREL_OFFSET = drpa_pkg::BarrelOffsetDefault
) (
   input logic clock,
   input logic reset,
   drpa_req_if.sink   req,
   drpa_rsp_if.source rsp,
   drpa_csr_if.sink   csr
);
   localparam int BINS = BARREL_BINS + 2 * ENDCAP_RINGS;
   localparam int AW   = $clog2(BINS);
   localparam int SW   = drpa_pkg::SumWidth;
   localparam int CW   = drpa_pkg::CountWidth;
   localparam int DW   = 4 * SW + CW;
   localparam int RW   = $clog2(ENDCAP_RINGS + 1);

   drpa_pkg::state_type state_ff, state_in;
   drpa_pkg::req_type   item_ff, item_in;
   drpa_pkg::rsp_type   out_ff, out_in;
   logic [31:0]   limit_ff;
   logic [5:0]    radius_ff;
   logic [AW-1:0] bin_ff, bin_in;
   logic [1:0]    reg_ff, reg_in;
   logic [7:0]    ring_ff, ring_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          clear_busy, rd_en, wr_en;
   logic [DW-1:0] rd_data, wr_data;
   logic          rf_start, rf_done, rf_found;
   logic [RW-1:0] rf_ring;
   logic          dv_start;
   logic [3:0]    dv_done;
   logic [31:0]   dv_q [4];
   logic signed [SW-1:0] sums [4];
   logic [CW-1:0] count;
   logic signed [8:0] eta;
   logic [SW-1:0] new_sum [4];

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == drpa_pkg::ST_IDLE) && !clear_busy && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= drpa_pkg::BarrelLimitReset;
         radius_ff <= drpa_pkg::FirstRadiusReset;
      end else if (csr.valid) begin
         unique case (csr.data.index)
            drpa_pkg::CsrBarrelLimit: limit_ff  <= csr.data.data;
            drpa_pkg::CsrFirstRadius: radius_ff <= csr.data.data[5:0];
            default: ;
         endcase
      end
   end

   drpa_ring_find #(.ENDCAP_RINGS(ENDCAP_RINGS)) u_ring (
      .clock, .reset, .start(rf_start),
      .grid_x(item_ff.raw_id[13:7]), .grid_y(item_ff.raw_id[6:0]),
      .first_radius(radius_ff), .done(rf_done), .found(rf_found), .ring(rf_ring)
   );

   drpa_bin_store #(.BINS(BINS)) u_store (
      .clock, .reset, .clear_busy, .rd_en, .rd_addr(bin_in), .rd_data,
      .wr_en, .wr_addr(bin_ff), .wr_data
   );

   for (genvar k = 0; k < 4; k++) begin : g_div
      assign sums[k] = rd_data[DW-1-k*SW -: SW];
      drpa_divider u_div (
         .clock, .reset, .start(dv_start), .dividend(sums[k]), .divisor(count),
         .done(dv_done[k]), .quotient(dv_q[k])
      );
   end
   assign count = rd_data[CW-1:0];

   assign eta = item_ff.raw_id[16] ? $signed({2'b0, item_ff.raw_id[15:9]})
                                   : -$signed({2'b0, item_ff.raw_id[15:9]});
   always_comb begin
      new_sum[0] = sums[0] + SW'(item_ff.amplitude);
      new_sum[1] = sums[1] + SW'(item_ff.start_time);
      new_sum[2] = sums[2] + SW'(item_ff.alpha_shape);
      new_sum[3] = sums[3] + SW'(item_ff.beta_shape);
      wr_data = {new_sum[0], new_sum[1], new_sum[2], new_sum[3], count + CW'(1)};
   end

   always_comb begin
      logic signed [9:0] idx;
      idx = 10'(eta) + 10'(BARREL_OFFSET);
      state_in     = state_ff;
      item_in      = item_ff;
      out_in       = out_ff;
      bin_in       = bin_ff;
      reg_in       = reg_ff;
      ring_in      = ring_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      rf_start     = 1'b0;
      dv_start     = 1'b0;
      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         drpa_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               item_in  = req.data;
               ring_in  = '0;
               state_in = drpa_pkg::ST_CLASS;
            end
         end
         drpa_pkg::ST_CLASS: begin
            out_in = '0;
            if (item_ff.command == drpa_pkg::CmdRead) begin
               reg_in  = item_ff.read_region;
               ring_in = item_ff.read_ring;
               out_in.status = drpa_pkg::StatusReadEmpty;
               out_in.region = item_ff.read_region;
               out_in.ring_number = item_ff.read_ring;
               if (item_ff.read_region == drpa_pkg::RegionBarrel &&
                   {24'b0, item_ff.read_ring} < BARREL_BINS &&
                   {24'b0, item_ff.read_ring} != BARREL_OFFSET) begin
                  bin_in = AW'(item_ff.read_ring);
                  state_in = drpa_pkg::ST_READ;
               end else if ((item_ff.read_region == drpa_pkg::RegionPlus ||
                             item_ff.read_region == drpa_pkg::RegionMinus) &&
                            {24'b0, item_ff.read_ring} < ENDCAP_RINGS) begin
                  bin_in = AW'(BARREL_BINS) + AW'(item_ff.read_ring) +
                           ((item_ff.read_region == drpa_pkg::RegionMinus)
                            ? AW'(ENDCAP_RINGS) : AW'(0));
                  state_in = drpa_pkg::ST_READ;
               end else begin
                  state_in = drpa_pkg::ST_OUT;
               end
            end else if (item_ff.raw_id < limit_ff) begin
               if (idx < 0 || idx >= 10'(BARREL_BINS)) begin
                  out_in.status = drpa_pkg::StatusDropped;
                  state_in = drpa_pkg::ST_OUT;
               end else begin
                  reg_in  = drpa_pkg::RegionBarrel;
                  ring_in = 8'(idx);
                  bin_in  = AW'(idx);
                  state_in = drpa_pkg::ST_READ;
               end
            end else if (!rf_done) begin
               // Ring search runs while we wait in this state.
               rf_start = (ring_ff != 8'hFF);
               ring_in  = 8'hFF;
            end else begin
               ring_in = 8'(rf_ring);
               if (!rf_found) begin
                  out_in.status = drpa_pkg::StatusDropped;
                  state_in = drpa_pkg::ST_OUT;
               end else begin
                  reg_in = item_ff.raw_id[14] ? drpa_pkg::RegionPlus
                                              : drpa_pkg::RegionMinus;
                  bin_in = AW'(BARREL_BINS) + AW'(rf_ring) +
                           (item_ff.raw_id[14] ? AW'(0) : AW'(ENDCAP_RINGS));
                  state_in = drpa_pkg::ST_READ;
               end
            end
            if (state_in != drpa_pkg::ST_CLASS) begin
               rd_en = (state_in == drpa_pkg::ST_READ);
            end
         end
         drpa_pkg::ST_READ: begin
            out_in.region = reg_ff;
            out_in.ring_number = ring_ff;
            if (item_ff.command == drpa_pkg::CmdRead) begin
               if (count == '0) begin
                  state_in = drpa_pkg::ST_OUT;
               end else begin
                  dv_start = 1'b1;
                  state_in = drpa_pkg::ST_DIVIDE;
               end
            end else if (count == drpa_pkg::CountMax) begin
               out_in.status = drpa_pkg::StatusDropped;
               out_in.crystal_count = count;
               state_in = drpa_pkg::ST_OUT;
            end else begin
               wr_en = 1'b1;
               out_in.status = drpa_pkg::StatusAccum;
               out_in.crystal_count = count + CW'(1);
               state_in = drpa_pkg::ST_OUT;
            end
         end
         drpa_pkg::ST_DIVIDE: begin
            if (dv_done[0]) begin
               out_in.status = drpa_pkg::StatusReadOk;
               out_in.mean_amplitude  = dv_q[0];
               out_in.mean_start_time = dv_q[1];
               out_in.mean_alpha      = dv_q[2];
               out_in.mean_beta       = dv_q[3];
               out_in.crystal_count   = count;
               state_in = drpa_pkg::ST_OUT;
            end
         end
         drpa_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               state_in = drpa_pkg::ST_IDLE;
            end
         end
         default: state_in = drpa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drpa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ring_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_ff      <= ring_in;
      end
      item_ff <= item_in;
      out_ff  <= out_in;
      bin_ff  <= bin_in;
      reg_ff  <= reg_in;
   end

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req.ready) else $error("item accepted during clearing pass");
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> !wr_en) else $error("back-to-back bin writes");
   a_div_in_sync: assert property (@(posedge clock) disable iff (reset)
      dv_done[0] |-> dv_done[3]) else $error("divider lanes out of step");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
endmodule

// ===== bench/tb_top.sv =====
// Testbench for the detector ring parameter averager: drives accumulate and read items,
// predicts every result from a model of the bins, and compares each whole result with its prediction.
// Depends on drpa_pkg, drpa_if and the core with its submodules.
`timescale 1ns / 1ps
module tb_top;
   localparam int NumBins   = 171 + 2 * 40;
   localparam int WatchLimit = 20000;

   logic clock;
   logic reset;

   drpa_req_if req_ch ();
   drpa_rsp_if rsp_ch ();
   drpa_csr_if csr_ch ();

   detector_ring_parameter_averager_core uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   // Shadow copy of the block's registers and bins.
   logic [31:0]        barrel_limit;
   logic [5:0]         first_radius;
   logic signed [47:0] sums [NumBins][4];
   int unsigned        counts [NumBins];

   drpa_pkg::rsp_type expected_q [$];
   int      errors;
   int      idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [31:0] param_of(input drpa_pkg::req_type r, input int k);
      case (k)
         0: param_of = r.amplitude;
         1: param_of = r.start_time;
         2: param_of = r.alpha_shape;
         default: param_of = r.beta_shape;
      endcase
   endfunction

   // Works out the result of one item and updates the shadow bins.
   function automatic drpa_pkg::rsp_type predict_bin_result(input drpa_pkg::req_type r);
      drpa_pkg::rsp_type res;
      int eta, dx, dy, sq_dist, lo, hi, ring, bin;
      logic [1:0] reg_code;
      logic signed [63:0] q;
      bit found;
      res = '0;
      bin = -1;
      if (r.command == drpa_pkg::CmdAccum) begin
         if (r.raw_id < barrel_limit) begin
            eta = int'(r.raw_id[15:9]);
            if (!r.raw_id[16]) eta = -eta;
            if (eta + 85 >= 0 && eta + 85 < 171) begin
               reg_code = drpa_pkg::RegionBarrel;
               ring = eta + 85;
               bin = ring;
            end
         end else begin
            dx = 2 * int'(r.raw_id[13:7]) - 101;
            dy = 2 * int'(r.raw_id[6:0]) - 101;
            sq_dist = dx * dx + dy * dy;
            found = 0;
            for (int j = 0; j < 40 && !found; j++) begin
               lo = 2 * (int'(first_radius) + j);
               hi = lo + 2;
               if (sq_dist > lo * lo && sq_dist < hi * hi) begin
                  found = 1;
                  ring = j;
               end
            end
            if (found) begin
               reg_code = r.raw_id[14] ? drpa_pkg::RegionPlus : drpa_pkg::RegionMinus;
               bin = 171 + (int'(reg_code) - 1) * 40 + ring;
            end
         end
         if (bin < 0) begin
            res.status = drpa_pkg::StatusDropped;
         end else if (counts[bin] >= 4095) begin
            res.status = drpa_pkg::StatusDropped;
            res.region = reg_code;
            res.ring_number = 8'(ring);
            res.crystal_count = drpa_pkg::CountMax;
         end else begin
            for (int k = 0; k < 4; k++) sums[bin][k] = sums[bin][k] + 48'(param_of(r, k));
            counts[bin]++;
            res.status = drpa_pkg::StatusAccum;
            res.region = reg_code;
            res.ring_number = 8'(ring);
            res.crystal_count = 12'(counts[bin]);
         end
      end else begin
         res.status = drpa_pkg::StatusReadEmpty;
         res.region = r.read_region;
         res.ring_number = r.read_ring;
         if (r.read_region == drpa_pkg::RegionBarrel) begin
            if (r.read_ring < 171 && r.read_ring != 85) bin = int'(r.read_ring);
         end else if (r.read_region != 2'd3 && r.read_ring < 40) begin
            bin = 171 + (int'(r.read_region) - 1) * 40 + int'(r.read_ring);
         end
         if (bin >= 0 && counts[bin] != 0) begin
            res.status = drpa_pkg::StatusReadOk;
            res.crystal_count = 12'(counts[bin]);
            // SystemVerilog division truncates toward zero, as the block does.
            q = sums[bin][0] / $signed({32'd0, counts[bin]}); res.mean_amplitude = q[31:0];
            q = sums[bin][1] / $signed({32'd0, counts[bin]}); res.mean_start_time = q[31:0];
            q = sums[bin][2] / $signed({32'd0, counts[bin]}); res.mean_alpha = q[31:0];
            q = sums[bin][3] / $signed({32'd0, counts[bin]}); res.mean_beta = q[31:0];
         end
      end
      return res;
   endfunction

   // Valid stays high after an accept until the next item or a drain takes it down.
   task automatic send_item(input drpa_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 16);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      expected_q.push_back(predict_bin_result(r));
   endtask

   task automatic write_register(input logic idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= '{index: idx, data: value};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == drpa_pkg::CsrBarrelLimit) barrel_limit = value;
      else first_radius = value[5:0];
      @(posedge clock);
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic drpa_pkg::req_type random_params(input drpa_pkg::req_type r);
      r.amplitude   = $urandom;
      r.start_time  = $urandom;
      r.alpha_shape = $urandom;
      r.beta_shape  = $urandom;
      return r;
   endfunction

   function automatic drpa_pkg::req_type barrel_item(input int eta, input bit plus);
      drpa_pkg::req_type r;
      r = random_params('0);
      r.raw_id = {15'($urandom_range(0, 12799)), plus, 7'(eta), 9'($urandom)};
      r.command = drpa_pkg::CmdAccum;
      return r;
   endfunction

   function automatic drpa_pkg::req_type endcap_item(input int x, input int y, input bit plus);
      drpa_pkg::req_type r;
      r = random_params('0);
      r.raw_id = {16'($urandom_range(51200, 65535)), 1'b0, plus, 7'(x), 7'(y)};
      r.command = drpa_pkg::CmdAccum;
      return r;
   endfunction

   function automatic drpa_pkg::req_type read_item(input logic [1:0] region,
                                                   input logic [7:0] ring);
      drpa_pkg::req_type r;
      r = random_params('0);
      r.raw_id = $urandom;
      r.command = drpa_pkg::CmdRead;
      r.read_region = region;
      r.read_ring = ring;
      return r;
   endfunction

   task automatic test_directed;
      drpa_pkg::req_type r;
      send_item(read_item(drpa_pkg::RegionBarrel, 8'd10));
      r = barrel_item(0, 1'b1);
      r.amplitude = 32'sh7FFFFFFF; r.start_time = 32'sh80000000;
      send_item(r);
      send_item(barrel_item(85, 1'b1));
      send_item(barrel_item(85, 1'b0));
      send_item(barrel_item(86, 1'b1));
      send_item(barrel_item(127, 1'b0));
      send_item(barrel_item(3, 1'b0));
      send_item(read_item(drpa_pkg::RegionBarrel, 8'd85));
      send_item(read_item(drpa_pkg::RegionBarrel, 8'd170));
      send_item(read_item(drpa_pkg::RegionBarrel, 8'd82));
      send_item(read_item(drpa_pkg::RegionBarrel, 8'd171));
      send_item(read_item(2'd3, 8'd5));
      send_item(read_item(drpa_pkg::RegionPlus, 8'd40));
      send_item(read_item(drpa_pkg::RegionMinus, 8'd255));
      send_item(endcap_item(50, 64, 1'b1));
      send_item(endcap_item(50, 64, 1'b0));
      send_item(endcap_item(50, 50, 1'b1));
      send_item(endcap_item(0, 0, 1'b0));
      send_item(endcap_item(127, 127, 1'b1));
      send_item(read_item(drpa_pkg::RegionPlus, 8'd2));
      r = read_item(drpa_pkg::RegionMinus, 8'd2);
      r.raw_id = 32'hFFFFFFFF;
      send_item(r);
      r = endcap_item(50, 80, 1'b1);
      r.raw_id = 32'hFFFFFFFF;
      send_item(r);
      drain();
   endtask

   // Piles many items into one barrel bin, then reads its means back.
   task automatic test_bin_fill;
      for (int i = 0; i < 200; i++) send_item(barrel_item(20, 1'b1));
      send_item(read_item(drpa_pkg::RegionBarrel, 8'd105));
      drain();
   endtask

   task automatic random_phase(input int n);
      drpa_pkg::req_type r;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) r = barrel_item($urandom_range(0, 90), 1'($urandom));
         else if (pick < 80)
            r = endcap_item($urandom_range(0, 101), $urandom_range(0, 101), 1'($urandom));
         else if (pick < 90)
            r = read_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 40)));
         else if (pick < 95) r = read_item(2'($urandom_range(0, 3)), 8'($urandom));
         else begin
            r = random_params('0);
            r.raw_id = $urandom;
            r.command = 1'($urandom);
            r.read_region = 2'($urandom);
            r.read_ring = 8'($urandom);
         end
         send_item(r);
      end
   endtask

   task automatic test_random_settings;
      random_phase(400);
      drain();
      write_register(drpa_pkg::CsrBarrelLimit, 32'd0);
      write_register(drpa_pkg::CsrFirstRadius, 32'd0);
      random_phase(300);
      drain();
      write_register(drpa_pkg::CsrBarrelLimit, 32'hFFFFFFFF);
      write_register(drpa_pkg::CsrFirstRadius, 32'd63);
      random_phase(200);
      drain();
      write_register(drpa_pkg::CsrBarrelLimit, 32'd50000);
      write_register(drpa_pkg::CsrFirstRadius, 32'd5);
      random_phase(300);
      drain();
      write_register(drpa_pkg::CsrBarrelLimit, $urandom);
      write_register(drpa_pkg::CsrFirstRadius, $urandom);
      random_phase(200);
   endtask

   initial begin
      errors = 0;
      barrel_limit = drpa_pkg::BarrelLimitReset;
      first_radius = drpa_pkg::FirstRadiusReset;
      for (int b = 0; b < NumBins; b++) begin
         counts[b] = 0;
         for (int k = 0; k < 4; k++) sums[b][k] = '0;
      end
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      write_register(drpa_pkg::CsrFirstRadius, 32'd11);
      test_bin_fill();
      test_random_settings();
      drain();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Receiver with random stalls; checks each result against the oldest expectation.
   initial begin
      drpa_pkg::rsp_type want;
      int stall;
      rsp_ch.ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result %p", $time, rsp_ch.data);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (want !== rsp_ch.data)
                  $display("%0t mismatch expected %p actual %p", $time, want, rsp_ch.data);
               if (want !== rsp_ch.data) errors++;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end
endmodule
